/* rtl/etlu_pkg.sv */
// shared types and constants for the embedding table lookup and update block
// no dependencies; imported by the controller, the datapath and the top level
package etlu_pkg;

  localparam int ENTRIES  = 1024;
  localparam int MAX_DIM  = 64;

  localparam int ROW_W    = $clog2(ENTRIES);
  localparam int COL_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int VAL_W    = 16;
  localparam int RATE_W   = 16;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W   = RATE_W + VAL_W + 1;

  // item opcodes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_ENABLE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_INDEX    = 4'd3;

  // reset values
  localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(MAX_DIM);
  localparam logic [ROW_W-1:0]  NULL_RESET = ROW_W'(ENTRIES - 1);

  // controller to datapath
  typedef struct packed {
    logic              take_item;
    logic              mem_we;
    logic              mem_re;
    logic              wr_update;
    logic              col_from_item;
    logic [COL_W-1:0]  col;
    logic              lk_issue;
    logic              lk_last;
    logic              lk_zero;
    logic [RATE_W-1:0] learn_rate;
  } etlu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_space;
  } etlu_stat_t;

endpackage

/* rtl/etlu_dpath.sv */
// datapath: vector memory, item registers, update multiply and saturate,
// two-entry result queue; depends on etlu_pkg
module etlu_dpath
  import etlu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  etlu_cmd_t               cmd,
  output etlu_stat_t              stat,
  input  logic [ROW_W-1:0]        word_in,
  input  logic [COL_W-1:0]        elem_in,
  input  logic signed [VAL_W-1:0] value_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] value_out,
  output logic [COL_W-1:0]        element_out,
  output logic                    last
);

  logic [VAL_W-1:0] mem [0:(1 << ADDR_W) - 1];

  logic [ROW_W-1:0]         word_q;
  logic [COL_W-1:0]         elem_q;
  logic signed [VAL_W-1:0]  value_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]         mem_q;

  logic             lk_inflight;
  logic [COL_W-1:0] lk_elem_q;
  logic             lk_last_q;
  logic             lk_zero_q;

  logic [VAL_W-1:0] fifo_val  [0:1];
  logic [COL_W-1:0] fifo_elem [0:1];
  logic             fifo_last [0:1];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fcnt;

  logic [ADDR_W-1:0]        addr;
  logic [COL_W-1:0]         col;
  logic signed [PROD_W-1:0] rounded;
  logic signed [VAL_W:0]    rnd;
  logic signed [VAL_W+1:0]  sum;
  logic signed [VAL_W-1:0]  sat;
  logic [VAL_W-1:0]         wdata;
  logic                     push;
  logic                     pop;
  logic [2:0]               occ;

  assign col  = cmd.col_from_item ? elem_q : cmd.col;
  assign addr = {word_q, col};

  // round half up, then saturating add
  always_comb begin
    rounded = prod_q + PROD_W'(32768);
    rnd     = rounded[PROD_W-1:VAL_W];
    sum     = {{2{mem_q[VAL_W-1]}}, mem_q} + {rnd[VAL_W], rnd};
    if (sum > (VAL_W+2)'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -(VAL_W+2)'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[VAL_W-1:0];
    end
    wdata = cmd.wr_update ? sat : value_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      word_q  <= word_in;
      elem_q  <= elem_in;
      value_q <= value_in;
    end
    prod_q <= $signed({1'b0, cmd.learn_rate}) * value_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end else if (cmd.mem_re) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_inflight <= 1'b0;
    end else begin
      lk_inflight <= cmd.lk_issue;
    end
    lk_elem_q <= cmd.col;
    lk_last_q <= cmd.lk_last;
    lk_zero_q <= cmd.lk_zero;
  end

  assign push = lk_inflight;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fcnt <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fcnt <= fcnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      fifo_val[wptr]  <= lk_zero_q ? '0 : mem_q;
      fifo_elem[wptr] <= lk_elem_q;
      fifo_last[wptr] <= lk_last_q;
    end
  end

  assign out_valid   = (fcnt != 2'd0);
  assign value_out   = fifo_val[rptr];
  assign element_out = fifo_elem[rptr];
  assign last        = fifo_last[rptr];

  // room for one more read counting the one in flight and a pop this cycle
  assign occ            = {1'b0, fcnt} + 3'(lk_inflight);
  assign stat.out_space = (occ < 3'd2) || ((occ == 3'd2) && pop);

  a_port_single: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_we && cmd.mem_re))
    else $error("memory write and read in one cycle");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcnt != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (lk_inflight && fcnt == 2'd2) |-> pop)
    else $error("lookup read returns into a full queue");

endmodule

/* rtl/etlu_ctrl.sv */
// controller: configuration registers and the item sequencer
// depends on etlu_pkg; drives the datapath through etlu_cmd_t
module etlu_ctrl
  import etlu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      op,
  input  logic [ROW_W-1:0]     word_index,
  input  logic [COL_W-1:0]     element_index,
  output etlu_cmd_t            cmd,
  input  etlu_stat_t           stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_UPD_RD,
    S_UPD_WR,
    S_LOOKUP
  } state_t;

  state_t state;

  logic [DIM_W-1:0]  dim_in_use;
  logic [RATE_W-1:0] learn_rate;
  logic              update_enable;
  logic [ROW_W-1:0]  null_index;
  logic [DIM_W-1:0]  cnt;
  logic              is_null_q;

  logic [DIM_W-1:0] dim_eff;
  logic [DIM_W-1:0] cnt_next;
  logic             cnt_last;
  logic             in_row;
  logic             is_null;
  logic             accept;

  always_comb begin
    if (dim_in_use == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_in_use > DIM_W'(MAX_DIM)) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = dim_in_use;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_row    = {1'b0, element_index} < dim_eff;
  assign is_null   = (word_index == null_index);
  assign cnt_next  = cnt + 1'b1;
  assign cnt_last  = (cnt_next == dim_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      is_null_q     <= 1'b0;
      dim_in_use    <= DIM_RESET;
      learn_rate    <= '0;
      update_enable <= 1'b1;
      null_index    <= NULL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIM_IN_USE:    dim_in_use    <= cfg_data[DIM_W-1:0];
          REG_LEARN_RATE:    learn_rate    <= cfg_data[RATE_W-1:0];
          REG_UPDATE_ENABLE: update_enable <= cfg_data[0];
          REG_NULL_INDEX:    null_index    <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_null_q <= is_null;
            case (op)
              OP_LOAD:   state <= in_row ? S_LOAD : S_IDLE;
              OP_UPDATE: state <= (in_row && update_enable && !is_null) ? S_UPD_RD : S_IDLE;
              OP_LOOKUP: state <= S_LOOKUP;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_LOAD:   state <= S_IDLE;
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: state <= S_IDLE;
        S_LOOKUP: begin
          if (stat.out_space) begin
            if (cnt_last) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd               = '0;
    cmd.take_item     = accept;
    cmd.learn_rate    = learn_rate;
    cmd.col           = cnt[COL_W-1:0];
    case (state)
      S_LOAD: begin
        cmd.mem_we        = 1'b1;
        cmd.col_from_item = 1'b1;
      end
      S_UPD_RD: begin
        cmd.mem_re        = 1'b1;
        cmd.col_from_item = 1'b1;
      end
      S_UPD_WR: begin
        cmd.mem_we        = 1'b1;
        cmd.wr_update     = 1'b1;
        cmd.col_from_item = 1'b1;
      end
      S_LOOKUP: begin
        cmd.mem_re   = stat.out_space;
        cmd.lk_issue = stat.out_space;
        cmd.lk_last  = cnt_last;
        cmd.lk_zero  = is_null_q;
      end
      default: ;
    endcase
  end

  a_cnt_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) |-> (cnt < dim_eff))
    else $error("element counter past the row width");

  a_upd_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD_RD) |=> (state == S_UPD_WR))
    else $error("update read not followed by its write");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == '0))
    else $error("element counter not cleared after a lookup");

endmodule

/* rtl/embedding_table_lookup_update.sv */
// embedding table lookup/update: a load writes its element, an update reads it and writes the sum back
// loads and updates that change nothing, and reserved ops, go back to idle without touching the memory
// lookup: elements come out one per cycle while the result queue has space
// a lookup holds the input until its last element is read; one memory port serves every op
// reset (rst, synchronous) restores the register defaults and clears the result queue
// table contents survive reset and are undefined until loaded
module embedding_table_lookup_update
  import etlu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,  // word_index[9:0], element_index[15:10], value_in[31:16]
  input  logic [OP_W-1:0]      s_tuser,  // op[1:0]
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,  // value_out[15:0], element_out[21:16], zero pad
  output logic                 m_tlast   // last element of a looked-up row
);

  etlu_cmd_t  cmd;
  etlu_stat_t stat;

  // input field unpack
  logic [ROW_W-1:0]        word_index;
  logic [COL_W-1:0]        element_index;
  logic signed [VAL_W-1:0] value_in;

  logic signed [VAL_W-1:0] value_out;
  logic [COL_W-1:0]        element_out;

  assign word_index    = s_tdata[ROW_W-1:0];
  assign element_index = s_tdata[ROW_W+COL_W-1:ROW_W];
  assign value_in      = s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];

  // sequencer: decides per transaction what the memory port does
  etlu_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .op            (s_tuser),
    .word_index    (word_index),
    .element_index (element_index),
    .cmd           (cmd),
    .stat          (stat)
  );

  // memory, update arithmetic and result queue
  etlu_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .word_in     (word_index),
    .elem_in     (element_index),
    .value_in    (value_in),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .value_out   (value_out),
    .element_out (element_out),
    .last        (m_tlast)
  );

  // result pack, pad to whole bytes
  assign m_tdata = {2'b00, element_out, value_out};

endmodule

/* tb/sv/etlu_checker.sv */
// checker for the embedding table lookup and update block: keeps its own copy of the table
// and registers, predicts every looked-up element and compares the result stream
// depends on etlu_pkg for widths, opcodes and register indexes
module etlu_checker
  import etlu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [31:0]          s_tdata,  // word_index[9:0], element_index[15:10], value_in[31:16]
  input  logic [OP_W-1:0]      s_tuser,  // op[1:0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [23:0]          m_tdata,  // value_out[15:0], element_out[21:16], zero pad
  input  logic                 m_tlast,
  output int                   mismatches,
  output int                   results_owed
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] col;
    logic             last;
  } elem_t;

  elem_t            row_elems_due[$];
  logic [VAL_W-1:0] shadow_table [ENTRIES*MAX_DIM];
  logic [DIM_W-1:0] row_width;
  logic [RATE_W-1:0] step_rate;
  logic             upd_on;
  logic [ROW_W-1:0] empty_row;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t checker: %s", $time, what);
  endtask

  always @(posedge clk) begin : observe
    elem_t            fresh;
    elem_t            want;
    logic [ROW_W-1:0] word;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] operand;
    int               width;
    longint           product;
    longint           total;
    if (rst) begin
      row_elems_due.delete();
      row_width = DIM_RESET;
      step_rate = '0;
      upd_on    = 1'b1;
      empty_row = NULL_RESET;
    end else begin
      // results are matched before this edge's item can add anything
      if (m_tvalid && m_tready) begin
        if (row_elems_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value %h col %0d last %b",
                                  m_tdata[VAL_W-1:0], m_tdata[VAL_W +: COL_W], m_tlast));
        end else begin
          want = row_elems_due.pop_front();
          if (m_tdata[VAL_W-1:0] !== want.value)
            flag_mismatch($sformatf("value_out %h, predicted %h at col %0d",
                                    m_tdata[VAL_W-1:0], want.value, want.col));
          if (m_tdata[VAL_W +: COL_W] !== want.col)
            flag_mismatch($sformatf("element_out %0d, predicted %0d",
                                    m_tdata[VAL_W +: COL_W], want.col));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("tlast %b, predicted %b at col %0d",
                                    m_tlast, want.last, want.col));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIM_IN_USE:    row_width = cfg_data[DIM_W-1:0];
          REG_LEARN_RATE:    step_rate = cfg_data[RATE_W-1:0];
          REG_UPDATE_ENABLE: upd_on    = cfg_data[0];
          REG_NULL_INDEX:    empty_row = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        word    = s_tdata[ROW_W-1:0];
        col     = s_tdata[ROW_W +: COL_W];
        operand = s_tdata[ROW_W+COL_W +: VAL_W];
        width   = (row_width == 0) ? 1 : (row_width > MAX_DIM) ? MAX_DIM : int'(row_width);
        case (s_tuser)
          OP_LOAD: begin
            if (col < width) shadow_table[{word, col}] = operand;
          end
          OP_UPDATE: begin
            if (col < width && upd_on && word != empty_row) begin
              // rate * gradient, rounded half up, then saturated add
              product = longint'(step_rate) * longint'($signed(operand));
              total   = longint'($signed(shadow_table[{word, col}])) + ((product + 32768) >>> 16);
              if (total > 32767) total = 32767;
              else if (total < -32768) total = -32768;
              shadow_table[{word, col}] = total[VAL_W-1:0];
            end
          end
          OP_LOOKUP: begin
            for (int i = 0; i < width; i++) begin
              fresh.value = (word == empty_row) ? '0 : shadow_table[{word, COL_W'(i)}];
              fresh.col   = COL_W'(i);
              fresh.last  = (i == width - 1);
              row_elems_due.push_back(fresh);
            end
          end
          default: ;
        endcase
      end
    end
    results_owed = row_elems_due.size();
  end

endmodule

/* tb/sv/embedding_table_lookup_update_test.sv */
// top of the embedding table lookup and update testbench: clock, reset, item and register
// stimulus with random idling on both streams; predictions and compares live in etlu_checker
// depends on etlu_pkg, etlu_checker and the block itself
module embedding_table_lookup_update_test;
  import etlu_pkg::*;

  // op code the block must ignore
  localparam logic [OP_W-1:0]  OP_RESERVED   = 2'd3;
  localparam logic [ROW_W-1:0] TOP_ROW       = ROW_W'(ENTRIES - 1);
  // loads and updates give no result, so settle also waits for their memory writes before a write
  localparam int               SETTLE_CYCLES = 8;
  localparam int               CYCLE_LIMIT   = 1000000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;  // word_index[9:0], element_index[15:10], value_in[31:16]
  logic [OP_W-1:0]      s_tuser;  // op[1:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [23:0]          m_tdata;  // value_out[15:0], element_out[21:16], zero pad
  logic                 m_tlast;

  int mismatches;
  int results_owed;
  int cycle_count;
  int items_sent;

  // idling odds in percent per cycle, changed per phase
  int send_gap_pct;
  int stall_pct;

  // which table entries hold a value, so nothing unwritten is ever read back
  logic [MAX_DIM-1:0] loaded_mask [ENTRIES];
  // effective row width as the block applies it
  int                 row_dim;
  // word index the block currently treats as the empty word
  logic [ROW_W-1:0]   null_row;
  // rows a phase keeps working on
  logic [ROW_W-1:0]   hot_rows [4];
  int                 hot_count;

  embedding_table_lookup_update dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  etlu_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure, a fresh coin every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // table words with the extremes showing up often
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // every element of the row up to the current width has been loaded
  function automatic bit row_ready(input logic [ROW_W-1:0] row);
    logic [MAX_DIM-1:0] need;
    need = (row_dim >= MAX_DIM) ? '1 : ((MAX_DIM'(1) << row_dim) - 1'b1);
    return (loaded_mask[row] & need) == need;
  endfunction

  // one item transaction, with a random idle gap in front of it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] word,
                           input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val);
    int gap;
    gap = 0;
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) gap++;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {val, col, word};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (op == OP_LOAD && col < row_dim) loaded_mask[word][col] = 1'b1;
  endtask

  // one register write transaction; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DIM_IN_USE) begin
      row_dim = (data[DIM_W-1:0] == 0) ? 1 :
                (data[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : int'(data[DIM_W-1:0]);
    end
    if (idx == REG_NULL_INDEX) null_row = data[ROW_W-1:0];
  endtask

  // hold the sender until every predicted element has come out
  task automatic drain();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // idle point for register writes: drained, and loads or updates in flight are done
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register setting with a random mix of well-formed traffic on a few rows
  task automatic run_phase(input logic [DIM_W-1:0] dim, input logic [RATE_W-1:0] rate,
                           input logic enable, input bit null_hot, input int gap_pct,
                           input int stall, input int rows, input int budget);
    int               first_item;
    int               roll;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    settle();
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    hot_count    = rows;
    // first hot row is always one of the table ends
    hot_rows[0] = $urandom_range(1) ? '0 : TOP_ROW;
    for (int k = 1; k < rows; k++) hot_rows[k] = ROW_W'($urandom_range(ENTRIES - 1));
    write_reg(REG_DIM_IN_USE, CFG_DAT_W'(dim));
    write_reg(REG_LEARN_RATE, rate);
    write_reg(REG_UPDATE_ENABLE, CFG_DAT_W'(enable));
    write_reg(REG_NULL_INDEX, null_hot ? CFG_DAT_W'(hot_rows[rows-1]) :
                                          CFG_DAT_W'($urandom_range(ENTRIES - 1)));
    first_item = items_sent;
    while (items_sent - first_item < budget) begin
      row  = hot_rows[$urandom_range(hot_count - 1)];
      roll = $urandom_range(99);
      if (roll < 4) begin
        // pressure: sender waits for the result stream to run dry
        drain();
      end else if (roll < 8) begin
        send_item(OP_RESERVED, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
      end else if (roll < 14 && row_dim < MAX_DIM) begin
        // load past the row width, dropped by the block
        send_item(OP_LOAD, row, COL_W'($urandom_range(MAX_DIM - 1, row_dim)), pick_value());
      end else if (roll < 42) begin
        // a lookup needs the whole row loaded first, but the null word reads as zeros
        if (row != null_row && !row_ready(row)) begin
          for (int c = 0; c < row_dim; c++)
            if (!loaded_mask[row][c]) send_item(OP_LOAD, row, COL_W'(c), pick_value());
        end
        send_item(OP_LOOKUP, row, COL_W'($urandom), VAL_W'($urandom));
      end else if (roll < 76) begin
        // updates only touch loaded elements, otherwise load it now
        col = COL_W'($urandom_range(row_dim - 1));
        send_item(loaded_mask[row][col] ? OP_UPDATE : OP_LOAD, row, col, pick_value());
      end else begin
        send_item(OP_LOAD, row, COL_W'($urandom_range(row_dim - 1)), pick_value());
      end
    end
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_LOAD;
    send_gap_pct = 0;
    stall_pct    = 0;
    row_dim      = MAX_DIM;
    null_row     = NULL_RESET;
    items_sent   = 0;
    hot_count    = 1;
    foreach (loaded_mask[r]) loaded_mask[r] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: four-wide rows, half step size, null word still at its reset value
    write_reg(REG_DIM_IN_USE, 16'd4);
    write_reg(REG_LEARN_RATE, 16'h8000);
    send_item(OP_LOAD, '0, 6'd0, 16'h7FFF);
    send_item(OP_LOAD, '0, 6'd1, 16'h8000);
    send_item(OP_LOAD, '0, 6'd2, 16'h0000);
    send_item(OP_LOAD, '0, 6'd3, 16'hFFFF);
    // element past the row width is dropped
    send_item(OP_LOAD, '0, 6'd63, 16'h1234);
    for (int c = 0; c < 4; c++) send_item(OP_LOAD, TOP_ROW, COL_W'(c), pick_value());
    send_item(OP_LOOKUP, '0, 6'd0, 16'h0000);
    // top row is the null word after reset, so zeros come back
    send_item(OP_LOOKUP, TOP_ROW, 6'd63, 16'hFFFF);
    // saturation at both ends, then rounding of a half step down and up
    send_item(OP_UPDATE, '0, 6'd0, 16'h7FFF);
    send_item(OP_UPDATE, '0, 6'd1, 16'h8000);
    send_item(OP_UPDATE, '0, 6'd2, 16'hFFFF);
    send_item(OP_UPDATE, '0, 6'd3, 16'h0001);
    // update of the null word is blocked
    send_item(OP_UPDATE, TOP_ROW, 6'd0, 16'h7FFF);
    send_item(OP_RESERVED, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
    send_item(OP_LOOKUP, '0, 6'd0, 16'h0000);

    // updates disabled, full step size, row 0 as null word, zero width acting as one
    settle();
    write_reg(REG_UPDATE_ENABLE, 16'd0);
    write_reg(REG_LEARN_RATE, 16'hFFFF);
    write_reg(REG_NULL_INDEX, 16'd0);
    write_reg(REG_DIM_IN_USE, 16'd0);
    send_item(OP_UPDATE, '0, 6'd0, 16'h7FFF);
    send_item(OP_UPDATE, TOP_ROW, 6'd0, 16'h8000);
    send_item(OP_LOOKUP, '0, 6'd0, 16'h0000);
    send_item(OP_LOOKUP, TOP_ROW, 6'd0, 16'h0000);

    // updates back on, two-wide rows; an update past the width is dropped
    settle();
    write_reg(REG_UPDATE_ENABLE, 16'd1);
    write_reg(REG_DIM_IN_USE, 16'd2);
    send_item(OP_UPDATE, TOP_ROW, 6'd1, 16'h8000);
    send_item(OP_UPDATE, TOP_ROW, 6'd3, 16'h7FFF);
    send_item(OP_LOOKUP, TOP_ROW, 6'd0, 16'h0000);
    send_item(OP_LOOKUP, '0, 6'd0, 16'h0000);

    // random phases over the register settings and idling patterns
    run_phase(7'd8,   16'h1000,            1'b1, 1'b1, 0,  0,  3, 14);
    run_phase(7'd3,   16'hFFFF,            1'b1, 1'b0, 47, 0,  3, 12);
    // widths above the row size act as full rows; one row, the null word, read as zeros
    run_phase(7'd127, 16'h0100,            1'b1, 1'b1, 0,  47, 1, 8);
    run_phase(7'd5,   RATE_W'($urandom),   1'b0, 1'b1, 26, 26, 3, 14);
    run_phase(7'd0,   16'h4000,            1'b1, 1'b1, 26, 26, 2, 8);
    run_phase(7'd7,   RATE_W'($urandom),   1'b1, 1'b1, 0,  0,  4, 20);

    drain();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/etlu_pkg.sv
rtl/etlu_dpath.sv
rtl/etlu_ctrl.sv
rtl/embedding_table_lookup_update.sv
tb/sv/etlu_checker.sv
tb/sv/embedding_table_lookup_update_test.sv
